>>> rtl/shxp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// shxp_pkg: shared types and constants of the sync header frame parser
// Codes, sync and token bytes, and the result record passed between stages.
// ----------------------------------------------------------------------------
package shxp_pkg;

    localparam logic [7:0] SYNC0 = 8'h55;
    localparam logic [7:0] SYNC1 = 8'h4E;
    localparam logic [7:0] SYNC2 = 8'h45;
    localparam logic [7:0] SYNC3 = 8'h52;
    localparam logic [7:0] TOKEN = 8'h3A;

    // XOR of the four sync bytes and the token; the length byte is added later
    localparam logic [7:0] XOR_SEED = SYNC0 ^ SYNC1 ^ SYNC2 ^ SYNC3 ^ TOKEN;

    localparam logic [7:0] TIMEOUT_RESET = 8'd3;

    localparam logic CMD_BYTE = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    localparam logic [1:0] KIND_BODY  = 2'd0;
    localparam logic [1:0] KIND_GOOD  = 2'd1;
    localparam logic [1:0] KIND_BAD   = 2'd2;
    localparam logic [1:0] KIND_ABORT = 2'd3;

    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] byte_value;
        logic [7:0] byte_index;
        logic       frame_last;
    } result_t;

    typedef struct packed {
        logic    valid;
        result_t data;
    } push_t;

endpackage

`default_nettype wire

>>> rtl/shxp_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// shxp_if: channel interfaces of the sync header frame parser
// Input channel carries bytes and ticks; output channel carries results.
// ----------------------------------------------------------------------------
interface shxp_in_if;
    logic       valid;
    logic       ready;
    logic       cmd;
    logic [7:0] rx_byte;

    modport source (output valid, output cmd, output rx_byte, input ready);
    modport sink   (input valid, input cmd, input rx_byte, output ready);
endinterface

interface shxp_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] byte_value;
    logic [7:0] byte_index;
    logic       frame_last;

    modport source (output valid, output kind, output byte_value, output byte_index,
                    output frame_last, input ready);
    modport sink   (input valid, input kind, input byte_value, input byte_index,
                    input frame_last, output ready);
endinterface

`default_nettype wire

>>> rtl/sync_header_xor_frame_parser.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sync_header_xor_frame_parser: receive-side deframer with XOR checksum
// Hunts for the sync header, tracks the length, streams body bytes and
// closes each frame with a good, bad or timeout result.
// ----------------------------------------------------------------------------
//  Channel   Dir  Handshake      Contents
//  link      in   valid/ready    cmd (byte or tick), rx_byte
//  parsed    out  valid/ready    kind, byte_value, byte_index, frame_last
//  cfg       in   cfg_wr_en      cfg_wr_data -> timeout_ticks
//
//  One word is taken every cycle while link.ready is high. Its result
//  enters the queue at the accepting edge, is popped from there into the
//  output register and then shows on parsed.
//  link.ready drops only while the result queue is full, i.e. while parsed
//  stalls long enough to back up the queue.
//  rst_n is asynchronous: hunting state, empty queue, timeout_ticks of 3.
// ----------------------------------------------------------------------------
module sync_header_xor_frame_parser
#(
    parameter int QUEUE_DEPTH = shxp_pkg::QUEUE_DEPTH
)
(
    input  var logic       clk,
    input  var logic       rst_n,
    input  var logic       cfg_wr_en,
    input  var logic [7:0] cfg_wr_data,
    shxp_in_if.sink        link,
    shxp_out_if.source     parsed
);

    // front to queue: optional result record per accepted word
    shxp_pkg::push_t   push;
    logic              space;

    // queue to back
    logic              q_valid;
    shxp_pkg::result_t q_data;
    logic              pop;

    // Parse bytes and ticks; hold the header state, count and running XOR.
    shxp_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .space       (space),
        .link        (link),
        .push        (push)
    );

    // Decouple the parser from output stalls.
    shxp_queue
    #(
        .DEPTH (QUEUE_DEPTH)
    )
    u_queue
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .space   (space),
        .pop     (pop),
        .q_valid (q_valid),
        .q_data  (q_data)
    );

    // Drive the result channel from a register.
    shxp_back u_back
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_data  (q_data),
        .pop     (pop),
        .parsed  (parsed)
    );

endmodule

`default_nettype wire

>>> rtl/shxp_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// shxp_front: header hunt, length tracking, checksum and timeout
// Accepts one word per cycle while space is high; pushes at most one record.
// ----------------------------------------------------------------------------
module shxp_front
(
    input  var logic             clk,
    input  var logic             rst_n,
    input  var logic             cfg_wr_en,
    input  var logic [7:0]       cfg_wr_data,
    input  var logic             space,
    shxp_in_if.sink              link,
    output var shxp_pkg::push_t  push
);

    typedef enum logic [2:0] {
        ST_HUNT = 3'd0,
        ST_N    = 3'd1,
        ST_E    = 3'd2,
        ST_R    = 3'd3,
        ST_LEN  = 3'd4,
        ST_TOK  = 3'd5,
        ST_BODY = 3'd6,
        ST_BAD  = 3'd7
    } state_t;

    state_t     state_reg, state_next;
    logic [7:0] timeout_reg;
    logic [7:0] bytes_left_reg, bytes_left_next;
    logic [7:0] xor_reg, xor_next;
    logic [7:0] pos_reg, pos_next;
    logic [7:0] ticks_reg, ticks_next;
    logic [7:0] ticks_dec;
    logic       accept;

    assign link.ready = space;
    assign accept     = link.valid && space;
    assign ticks_dec  = ticks_reg - 8'd1;

    always_comb
    begin
        state_next      = state_reg;
        bytes_left_next = bytes_left_reg;
        xor_next        = xor_reg;
        pos_next        = pos_reg;
        ticks_next      = ticks_reg;
        push.valid           = 1'b0;
        push.data.kind       = shxp_pkg::KIND_BODY;
        push.data.byte_value = link.rx_byte;
        push.data.byte_index = pos_reg;
        push.data.frame_last = 1'b0;

        if (accept)
        begin
            if (link.cmd == shxp_pkg::CMD_TICK)
            begin
                case (state_reg)
                    ST_HUNT:
                    begin
                    end
                    ST_N, ST_E, ST_R, ST_LEN, ST_TOK, ST_BODY:
                    begin
                        ticks_next = ticks_dec;
                        if (ticks_dec == 8'd0)
                        begin
                            state_next = ST_HUNT;
                            if (state_reg == ST_BODY)
                            begin
                                push.valid           = 1'b1;
                                push.data.kind       = shxp_pkg::KIND_ABORT;
                                push.data.byte_value = 8'd0;
                                push.data.frame_last = 1'b1;
                            end
                        end
                    end
                    default:
                    begin
                        state_next = ST_HUNT;
                    end
                endcase
            end
            else
            begin
                // on a mismatch, re-examine the byte as a frame start
                case (state_reg)
                    ST_N, ST_E, ST_R, ST_TOK, ST_HUNT:
                    begin
                        if ((state_reg == ST_N && link.rx_byte == shxp_pkg::SYNC1) ||
                            (state_reg == ST_E && link.rx_byte == shxp_pkg::SYNC2) ||
                            (state_reg == ST_R && link.rx_byte == shxp_pkg::SYNC3))
                        begin
                            state_next = state_t'(state_reg + 3'd1);
                        end
                        else if (state_reg == ST_TOK && link.rx_byte == shxp_pkg::TOKEN)
                        begin
                            state_next = ST_BODY;
                            xor_next   = shxp_pkg::XOR_SEED ^ bytes_left_reg;
                            pos_next   = 8'd0;
                        end
                        else if (link.rx_byte == shxp_pkg::SYNC0)
                        begin
                            state_next = ST_N;
                            ticks_next = timeout_reg;
                        end
                        else
                        begin
                            state_next = ST_HUNT;
                        end
                    end
                    ST_LEN:
                    begin
                        bytes_left_next = link.rx_byte;
                        state_next      = ST_TOK;
                    end
                    ST_BODY:
                    begin
                        push.valid      = 1'b1;
                        pos_next        = pos_reg + 8'd1;
                        bytes_left_next = bytes_left_reg - 8'd1;
                        if (bytes_left_reg == 8'd1)
                        begin
                            state_next           = ST_HUNT;
                            push.data.frame_last = 1'b1;
                            push.data.kind       = (link.rx_byte == xor_reg) ?
                                                   shxp_pkg::KIND_GOOD : shxp_pkg::KIND_BAD;
                        end
                        else
                        begin
                            xor_next = xor_reg ^ link.rx_byte;
                        end
                    end
                    default:
                    begin
                        state_next = ST_HUNT;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_HUNT;
            timeout_reg    <= shxp_pkg::TIMEOUT_RESET;
            bytes_left_reg <= 8'd0;
            xor_reg        <= 8'd0;
            pos_reg        <= 8'd0;
            ticks_reg      <= 8'd0;
        end
        else
        begin
            state_reg      <= state_next;
            bytes_left_reg <= bytes_left_next;
            xor_reg        <= xor_next;
            pos_reg        <= pos_next;
            ticks_reg      <= ticks_next;
            if (cfg_wr_en)
            begin
                timeout_reg <= cfg_wr_data;
            end
        end
    end

endmodule

`default_nettype wire

>>> rtl/shxp_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// shxp_queue: short result queue between front and back
// Circular buffer of result records with a fill count.
// ----------------------------------------------------------------------------
module shxp_queue
#(
    parameter int DEPTH = shxp_pkg::QUEUE_DEPTH
)
(
    input  var logic               clk,
    input  var logic               rst_n,
    input  var shxp_pkg::push_t    push,
    output var logic               space,
    input  var logic               pop,
    output var logic               q_valid,
    output var shxp_pkg::result_t  q_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    shxp_pkg::result_t mem [DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign space   = (count_reg != CNT_W'(DEPTH));
    assign q_valid = (count_reg != '0);
    assign q_data  = mem[rd_ptr_reg];
    assign do_push = push.valid && space;
    assign do_pop  = pop && q_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push.data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/shxp_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// shxp_back: output register of the result channel
// Pops a record whenever the output register is free or being taken.
// ----------------------------------------------------------------------------
module shxp_back
(
    input  var logic               clk,
    input  var logic               rst_n,
    input  var logic               q_valid,
    input  var shxp_pkg::result_t  q_data,
    output var logic               pop,
    shxp_out_if.source             parsed
);

    logic              valid_reg, valid_next;
    shxp_pkg::result_t data_reg;

    assign pop        = q_valid && (!valid_reg || parsed.ready);
    assign valid_next = pop || (valid_reg && !parsed.ready);

    assign parsed.valid      = valid_reg;
    assign parsed.kind       = data_reg.kind;
    assign parsed.byte_value = data_reg.byte_value;
    assign parsed.byte_index = data_reg.byte_index;
    assign parsed.frame_last = data_reg.frame_last;

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            data_reg <= q_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/shxp_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// shxp_checker: port-level checks of the frame parser
// Handshake hold, body index sequence, frame end fields, input readiness.
// ----------------------------------------------------------------------------
module shxp_checker
(
    input  var logic       clk,
    input  var logic       rst_n,
    input  var logic       link_ready,
    input  var logic       out_valid,
    input  var logic       out_ready,
    input  var logic [1:0] out_kind,
    input  var logic [7:0] out_byte_value,
    input  var logic [7:0] out_byte_index,
    input  var logic       out_frame_last
);

    logic       out_take;
    logic [7:0] exp_index_reg;

    assign out_take = out_valid && out_ready;

    // track the index that the next result must carry
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exp_index_reg <= 8'd0;
        end
        else if (out_take)
        begin
            exp_index_reg <= out_frame_last ? 8'd0 : out_byte_index + 8'd1;
        end
    end

    a_valid_hold : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    a_index_seq : assert property (@(posedge clk) disable iff (!rst_n)
        out_take |-> out_byte_index == exp_index_reg)
        else $error("result index out of sequence");

    a_end_fields : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_frame_last == (out_kind != shxp_pkg::KIND_BODY)) &&
                      (out_kind != shxp_pkg::KIND_ABORT || out_byte_value == 8'd0))
        else $error("frame end fields inconsistent");

    a_ready_free : assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> link_ready)
        else $error("input stalled with empty output");

endmodule

bind sync_header_xor_frame_parser shxp_checker u_shxp_checker
(
    .clk            (clk),
    .rst_n          (rst_n),
    .link_ready     (link.ready),
    .out_valid      (parsed.valid),
    .out_ready      (parsed.ready),
    .out_kind       (parsed.kind),
    .out_byte_value (parsed.byte_value),
    .out_byte_index (parsed.byte_index),
    .out_frame_last (parsed.frame_last)
);

`default_nettype wire

>>> sim/tb_sync_header_xor_frame_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sync_header_xor_frame_parser: self-checking bench for the frame parser
// Feeds bytes and ticks on the link channel, predicts every parsed result
// from a behavioral deframer, and compares each accepted result field by field.
// ----------------------------------------------------------------------------
module tb_sync_header_xor_frame_parser;

    localparam int HALF_PERIOD   = 5;
    localparam int RESET_CYCLES  = 3;
    localparam int SETTLE_CYCLES = 4;      // short pipe plus margin
    localparam int DRAIN_LIMIT   = 2000;   // cycles to wait for outstanding results
    localparam int HOLD_CYCLES   = 80;     // long receiver stall to back up the queue
    localparam int CHUNK_WORDS   = 105;    // frame words per random chunk
    localparam int NUM_CHUNKS    = 6;
    localparam time RUN_LIMIT    = 2_000_000;

    // Parser phases of the behavioral deframer
    typedef enum logic [2:0] {
        PH_HUNT,
        PH_WANT_N,
        PH_WANT_E,
        PH_WANT_R,
        PH_LENGTH,
        PH_TOKEN,
        PH_BODY
    } frame_phase_t;

    // ------------------------------------------------------------------------
    // Deframer scoreboard: tracks parser state on every accepted word and
    // holds the results the block still owes, oldest first.
    // ------------------------------------------------------------------------
    class deframe_checker;
        shxp_pkg::result_t owed_results[$];
        logic [7:0]        timeout_ticks;
        frame_phase_t      phase;
        logic [7:0]        bytes_left;
        logic [7:0]        running_xor;
        logic [7:0]        body_pos;
        logic [7:0]        ticks_left;
        int                errors;
        int                words_seen;
        int                kind_seen[4];

        function new();
            timeout_ticks = shxp_pkg::TIMEOUT_RESET;
            phase         = PH_HUNT;
            bytes_left    = '0;
            running_xor   = '0;
            body_pos      = '0;
            ticks_left    = '0;
            errors        = 0;
            words_seen    = 0;
            kind_seen     = '{0, 0, 0, 0};
        endfunction

        function void set_timeout(logic [7:0] value);
            timeout_ticks = value;
        endfunction

        function int pending();
            return owed_results.size();
        endfunction

        // A byte that breaks the header may itself open a new frame
        function void rehunt(logic [7:0] b);
            if (b == shxp_pkg::SYNC0) begin
                phase      = PH_WANT_N;
                ticks_left = timeout_ticks;
            end else begin
                phase = PH_HUNT;
            end
        endfunction

        function void owe(logic [1:0] kind, logic [7:0] value, logic [7:0] index,
                          logic last);
            shxp_pkg::result_t r;
            r.kind       = kind;
            r.byte_value = value;
            r.byte_index = index;
            r.frame_last = last;
            owed_results.push_back(r);
        endfunction

        function void note_word(logic cmd, logic [7:0] b);
            logic [7:0] pos;
            words_seen++;
            if (cmd == shxp_pkg::CMD_TICK) begin
                if (phase == PH_HUNT)
                    return;
                ticks_left = ticks_left - 8'd1;
                if (ticks_left != 0)
                    return;
                if (phase == PH_BODY)
                    owe(shxp_pkg::KIND_ABORT, 8'h00, body_pos, 1'b1);
                phase = PH_HUNT;
                return;
            end
            case (phase)
                PH_HUNT:   rehunt(b);
                PH_WANT_N: if (b == shxp_pkg::SYNC1) phase = PH_WANT_E; else rehunt(b);
                PH_WANT_E: if (b == shxp_pkg::SYNC2) phase = PH_WANT_R; else rehunt(b);
                PH_WANT_R: if (b == shxp_pkg::SYNC3) phase = PH_LENGTH; else rehunt(b);
                PH_LENGTH:
                begin
                    bytes_left = b;
                    phase      = PH_TOKEN;
                end
                PH_TOKEN:
                begin
                    if (b == shxp_pkg::TOKEN) begin
                        phase       = PH_BODY;
                        running_xor = shxp_pkg::XOR_SEED ^ bytes_left;
                        body_pos    = 8'd0;
                    end else begin
                        rehunt(b);
                    end
                end
                default:
                begin
                    pos      = body_pos;
                    body_pos = body_pos + 8'd1;
                    if (bytes_left != 8'd1) begin
                        bytes_left  = bytes_left - 8'd1;
                        running_xor = running_xor ^ b;
                        owe(shxp_pkg::KIND_BODY, b, pos, 1'b0);
                    end else begin
                        bytes_left = 8'd0;
                        phase      = PH_HUNT;
                        owe((b == running_xor) ? shxp_pkg::KIND_GOOD : shxp_pkg::KIND_BAD,
                            b, pos, 1'b1);
                    end
                end
            endcase
        endfunction

        function void check_result(shxp_pkg::result_t got);
            shxp_pkg::result_t want;
            string             field_name[4];
            int                want_f[4];
            int                got_f[4];
            field_name = '{"kind", "byte_value", "byte_index", "frame_last"};
            kind_seen[got.kind]++;
            if (owed_results.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %0d/%02h/%0d/%0d",
                         $time, got.kind, got.byte_value, got.byte_index, got.frame_last);
                errors++;
                return;
            end
            want   = owed_results.pop_front();
            want_f = '{want.kind, want.byte_value, want.byte_index, want.frame_last};
            got_f  = '{got.kind, got.byte_value, got.byte_index, got.frame_last};
            for (int i = 0; i < 4; i++) begin
                if (want_f[i] != got_f[i]) begin
                    $display("%0t: %s mismatch, expected %0d, actual %0d",
                             $time, field_name[i], want_f[i], got_f[i]);
                    errors++;
                end
            end
        endfunction

        // Report anything the block never delivered, then start clean
        function void drop_leftovers();
            foreach (owed_results[i]) begin
                $display("%0t: missing result, expected %0d/%02h/%0d/%0d, actual none",
                         $time, owed_results[i].kind, owed_results[i].byte_value,
                         owed_results[i].byte_index, owed_results[i].frame_last);
                errors++;
            end
            owed_results.delete();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset, channels and the block
    // ------------------------------------------------------------------------
    logic       clk;
    logic       rst_n;
    logic       cfg_wr_en;
    logic [7:0] cfg_wr_data;

    shxp_in_if  link_if();
    shxp_out_if parsed_if();

    sync_header_xor_frame_parser DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .link        (link_if),
        .parsed      (parsed_if)
    );

    deframe_checker chk;

    int         tx_idle_pct;      // percent of cycles the sender holds off
    int         rx_idle_pct;      // percent of cycles the receiver holds off
    bit         hold_req;         // ask the receiver for one long stall
    int         words_sent;
    int         noise_words;
    int         timeout_writes;
    logic [7:0] cur_timeout;

    initial
    begin
        clk = 1'b0;
        forever #HALF_PERIOD clk = ~clk;
    end

    // Hard stop in case the block hangs a handshake
    initial
    begin
        #RUN_LIMIT;
        $display("%0t: run limit reached", $time);
        $display("end of test: mismatches");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Monitor: sample both handshakes on the rising edge, before any update.
    // A result always belongs to an older word, so check before predicting.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        shxp_pkg::result_t got;
        if (rst_n) begin
            if (parsed_if.valid && parsed_if.ready) begin
                got.kind       = parsed_if.kind;
                got.byte_value = parsed_if.byte_value;
                got.byte_index = parsed_if.byte_index;
                got.frame_last = parsed_if.frame_last;
                chk.check_result(got);
            end
            if (link_if.valid && link_if.ready)
                chk.note_word(link_if.cmd, link_if.rx_byte);
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: random ready, or one long stall on request so the result
    // queue fills and the block has to drop link.ready.
    // ------------------------------------------------------------------------
    initial
    begin
        parsed_if.ready <= 1'b0;
        @(posedge rst_n);
        forever begin
            @(posedge clk);
            if (hold_req) begin
                hold_req = 1'b0;
                parsed_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                parsed_if.ready <= 1'b1;
            end else begin
                parsed_if.ready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Sender tasks
    // ------------------------------------------------------------------------

    // Offer one word after a random gap; return at the edge that takes it.
    // Valid stays high on return so back-to-back words need no new NBA.
    task automatic push_word(input logic cmd, input logic [7:0] b);
        while ($urandom_range(99) < tx_idle_pct) begin
            link_if.valid <= 1'b0;
            @(posedge clk);
        end
        link_if.valid   <= 1'b1;
        link_if.cmd     <= cmd;
        link_if.rx_byte <= b;
        @(posedge clk);
        while (!link_if.ready)
            @(posedge clk);
        words_sent++;
    endtask

    task automatic push_bytes(input logic [7:0] seq[$]);
        foreach (seq[i])
            push_word(shxp_pkg::CMD_BYTE, seq[i]);
    endtask

    // Tick with the given chance; the byte lane carries junk to show it is ignored
    task automatic maybe_tick(input int tick_pct);
        if ($urandom_range(99) < tick_pct)
            push_word(shxp_pkg::CMD_TICK, 8'($urandom));
    endtask

    // Complete frame: sync, length, token, body_cnt body bytes, checksum.
    // A body_cnt of 255 gives a length byte of zero, the 256-byte frame.
    task automatic send_frame(input int body_cnt, input bit spoil_cks, input int tick_pct);
        logic [7:0] len_byte;
        logic [7:0] acc;
        logic [7:0] b;
        logic [7:0] hdr[6];
        len_byte = 8'(body_cnt + 1);
        acc      = shxp_pkg::XOR_SEED ^ len_byte;
        hdr      = '{shxp_pkg::SYNC0, shxp_pkg::SYNC1, shxp_pkg::SYNC2, shxp_pkg::SYNC3,
                     len_byte, shxp_pkg::TOKEN};
        foreach (hdr[i]) begin
            maybe_tick(tick_pct);
            push_word(shxp_pkg::CMD_BYTE, hdr[i]);
        end
        for (int i = 0; i < body_cnt; i++) begin
            b   = 8'($urandom);
            acc = acc ^ b;
            maybe_tick(tick_pct);
            push_word(shxp_pkg::CMD_BYTE, b);
        end
        if (spoil_cks)
            acc = acc ^ 8'($urandom_range(255, 1));
        maybe_tick(tick_pct);
        push_word(shxp_pkg::CMD_BYTE, acc);
    endtask

    // Broken frames: cut sync, bad token, or a body that runs out of ticks
    task automatic send_broken();
        int         variant;
        int         n;
        logic [7:0] stray;
        logic [7:0] sync_seq[4];
        sync_seq = '{shxp_pkg::SYNC0, shxp_pkg::SYNC1, shxp_pkg::SYNC2, shxp_pkg::SYNC3};
        variant  = $urandom_range(2, 0);
        if (variant == 2 && cur_timeout > 8'd16)
            variant = 1;
        stray = $urandom_range(1, 0) ? shxp_pkg::SYNC0 : 8'($urandom);
        case (variant)
            0:
            begin
                n = $urandom_range(3, 1);
                for (int i = 0; i < n; i++)
                    push_word(shxp_pkg::CMD_BYTE, sync_seq[i]);
                push_word(shxp_pkg::CMD_BYTE, stray);
            end
            1:
            begin
                push_bytes('{shxp_pkg::SYNC0, shxp_pkg::SYNC1, shxp_pkg::SYNC2,
                             shxp_pkg::SYNC3, 8'($urandom), stray});
            end
            default:
            begin
                n = $urandom_range(6, 0);
                push_bytes('{shxp_pkg::SYNC0, shxp_pkg::SYNC1, shxp_pkg::SYNC2,
                             shxp_pkg::SYNC3, 8'(n + 2 + $urandom_range(5, 0)),
                             shxp_pkg::TOKEN});
                for (int i = 0; i < n; i++)
                    push_word(shxp_pkg::CMD_BYTE, 8'($urandom));
                repeat (cur_timeout)
                    push_word(shxp_pkg::CMD_TICK, 8'($urandom));
            end
        endcase
    endtask

    // Line noise: random bytes and ticks, mostly dropped by the hunt
    task automatic send_noise();
        int n;
        n = $urandom_range(3, 1);
        repeat (n) begin
            push_word(logic'($urandom_range(1, 0)), 8'($urandom));
            noise_words++;
        end
    endtask

    // Drop valid, wait for every owed result, then let the pipe go quiet
    task automatic drain_and_idle();
        link_if.valid <= 1'b0;
        for (int n = 0; n < DRAIN_LIMIT && chk.pending() != 0; n++)
            @(posedge clk);
        chk.drop_leftovers();
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_timeout(input logic [7:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        chk.set_timeout(value);
        cur_timeout = value;
        timeout_writes++;
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        int         chunk_start;
        int         pick;
        int         body_cnt;
        int         tick_pct;
        logic [7:0] next_timeout;

        chk            = new();
        tx_idle_pct    = 27;
        rx_idle_pct    = 54;
        hold_req       = 1'b0;
        words_sent     = 0;
        noise_words    = 0;
        timeout_writes = 0;
        cur_timeout    = shxp_pkg::TIMEOUT_RESET;

        rst_n           <= 1'b0;
        cfg_wr_en       <= 1'b0;
        cfg_wr_data     <= 8'h00;
        link_if.valid   <= 1'b0;
        link_if.cmd     <= shxp_pkg::CMD_BYTE;
        link_if.rx_byte <= 8'h00;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        repeat (SETTLE_CYCLES) @(posedge clk);

        // Directed part, timeout at its reset value of three ticks.
        // Tick while hunting and extreme noise bytes: no effect.
        push_word(shxp_pkg::CMD_TICK, 8'hFF);
        push_word(shxp_pkg::CMD_BYTE, 8'h00);
        push_word(shxp_pkg::CMD_BYTE, 8'hFF);
        // Length one: checksum only, no body byte
        send_frame(0, 1'b0, 0);
        // ID plus a bad checksum
        send_frame(1, 1'b1, 0);
        // Sync broken by a 'U' that restarts the header
        push_bytes('{shxp_pkg::SYNC0, shxp_pkg::SYNC1, shxp_pkg::SYNC0, shxp_pkg::SYNC1,
                     shxp_pkg::SYNC2, shxp_pkg::SYNC3, 8'h02, shxp_pkg::TOKEN,
                     8'hA5, shxp_pkg::XOR_SEED ^ 8'h02 ^ 8'hA5});
        // Token replaced by a 'U': restart, finish as a checksum-only frame
        push_bytes('{shxp_pkg::SYNC0, shxp_pkg::SYNC1, shxp_pkg::SYNC2, shxp_pkg::SYNC3,
                     8'h01, shxp_pkg::SYNC0, shxp_pkg::SYNC1, shxp_pkg::SYNC2,
                     shxp_pkg::SYNC3, 8'h01, shxp_pkg::TOKEN, shxp_pkg::XOR_SEED ^ 8'h01});
        // Countdown expires in the header: silent return to hunt
        push_bytes('{shxp_pkg::SYNC0, shxp_pkg::SYNC1});
        repeat (3) push_word(shxp_pkg::CMD_TICK, 8'h00);
        // Countdown expires in the body: abort after one body byte
        push_bytes('{shxp_pkg::SYNC0, shxp_pkg::SYNC1, shxp_pkg::SYNC2, shxp_pkg::SYNC3,
                     8'h05, shxp_pkg::TOKEN, 8'h7E});
        repeat (3) push_word(shxp_pkg::CMD_TICK, 8'h00);

        // Random part in chunks; each chunk gets a timeout written while idle.
        // Chunks 0-1: sender idles 27%, receiver 54%; 2-3 swapped; 4-5 none.
        for (int chunk = 0; chunk < NUM_CHUNKS; chunk++) begin
            drain_and_idle();
            case (chunk / 2)
                0:       begin tx_idle_pct = 27; rx_idle_pct = 54; end
                1:       begin tx_idle_pct = 54; rx_idle_pct = 27; end
                default: begin tx_idle_pct = 0;  rx_idle_pct = 0;  end
            endcase
            case (chunk)
                0:       next_timeout = 8'd1;
                1:       next_timeout = 8'd255;
                3:       next_timeout = 8'd2;
                default: next_timeout = 8'($urandom_range(255, 1));
            endcase
            write_timeout(next_timeout);

            if (chunk == 0) begin
                // Long receiver stall while a frame keeps flowing in
                hold_req = 1'b1;
                send_frame(20, 1'b0, 0);
            end
            if (chunk == 1) begin
                // Longest frames: length byte zero (256) and 255
                send_frame(255, 1'b0, 0);
                send_frame(254, 1'b1, 0);
            end

            chunk_start = words_sent - noise_words;
            while (words_sent - noise_words - chunk_start < CHUNK_WORDS) begin
                pick = $urandom_range(99);
                if (pick < 75) begin
                    body_cnt = ($urandom_range(19) == 0) ? $urandom_range(40, 13)
                                                         : $urandom_range(12, 0);
                    case ($urandom_range(2, 0))
                        0:       tick_pct = 0;
                        1:       tick_pct = 5;
                        default: tick_pct = 20;
                    endcase
                    send_frame(body_cnt, $urandom_range(4) == 0, tick_pct);
                end else if (pick < 85) begin
                    send_broken();
                end else begin
                    send_noise();
                end
            end
        end

        // Wind down: sender stops, every owed result must arrive
        drain_and_idle();

        $display("summary: %0d words accepted, results body %0d good %0d bad %0d abort %0d",
                 chk.words_seen, chk.kind_seen[shxp_pkg::KIND_BODY],
                 chk.kind_seen[shxp_pkg::KIND_GOOD], chk.kind_seen[shxp_pkg::KIND_BAD],
                 chk.kind_seen[shxp_pkg::KIND_ABORT]);
        $display("summary: %0d timeout settings, idle mixes 27/54, 54/27 and none",
                 timeout_writes);
        if (chk.errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
